/* src/vfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, constants and the sequencer program of the voxel face culler.
// ----------------------------------------------------------------------------
package vfc_pkg;

   localparam int DEF_MAX_WIDTH  = 16;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_TYPE_BITS  = 8;

   localparam int NUM_DIRS  = 6;
   localparam int UPC_BITS  = 4;
   localparam int UPC_DEPTH = 2 ** UPC_BITS;
   localparam int PROG_LEN  = 10;

   localparam logic [UPC_BITS-1:0] UPC_IDLE   = 4'd0;
   localparam logic [UPC_BITS-1:0] UPC_CENTER = 4'd1;
   localparam logic [UPC_BITS-1:0] UPC_EMIT   = 4'd9;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // neighbor codes double as face direction / visibility bit index
   typedef enum logic [2:0] {
      NBR_LEFT   = 3'd0,
      NBR_RIGHT  = 3'd1,
      NBR_FRONT  = 3'd2,
      NBR_BACK   = 3'd3,
      NBR_BOTTOM = 3'd4,
      NBR_TOP    = 3'd5,
      NBR_CENTER = 3'd6
   } nbr_sel_type;

   typedef enum logic [1:0] {
      CAP_NONE   = 2'd0,
      CAP_CENTER = 2'd1,
      CAP_VIS    = 2'd2
   } cap_type;

   typedef enum logic [2:0] {
      COND_NEVER  = 3'd0,
      COND_ALWAYS = 3'd1,
      COND_GO     = 3'd2,
      COND_AIR    = 3'd3,
      COND_LAST   = 3'd4
   } cond_type;

   typedef struct packed {
      nbr_sel_type         sel;
      cap_type             cap;
      logic [2:0]          vis_idx;
      logic                take;
      logic                emit;
      cond_type            cond;
      logic                hold;
      logic [UPC_BITS-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic go;
      logic air;
      logic emit_last;
   } seq_status_type;

   // Each step reads one cell; capturing steps take the cell read in the step before.
   localparam ctrl_word_type PROGRAM [UPC_DEPTH] = '{
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b1, 1'b0, COND_GO,     1'b1, UPC_CENTER},
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b0, 1'b0, COND_NEVER,  1'b0, UPC_IDLE},
      '{NBR_LEFT,   CAP_CENTER, 3'd0, 1'b0, 1'b0, COND_AIR,    1'b0, UPC_IDLE},
      '{NBR_RIGHT,  CAP_VIS,    3'd0, 1'b0, 1'b0, COND_NEVER,  1'b0, UPC_IDLE},
      '{NBR_FRONT,  CAP_VIS,    3'd1, 1'b0, 1'b0, COND_NEVER,  1'b0, UPC_IDLE},
      '{NBR_BACK,   CAP_VIS,    3'd2, 1'b0, 1'b0, COND_NEVER,  1'b0, UPC_IDLE},
      '{NBR_BOTTOM, CAP_VIS,    3'd3, 1'b0, 1'b0, COND_NEVER,  1'b0, UPC_IDLE},
      '{NBR_TOP,    CAP_VIS,    3'd4, 1'b0, 1'b0, COND_NEVER,  1'b0, UPC_IDLE},
      '{NBR_CENTER, CAP_VIS,    3'd5, 1'b0, 1'b0, COND_NEVER,  1'b0, UPC_IDLE},
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b0, 1'b1, COND_LAST,   1'b1, UPC_IDLE},
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b0, 1'b0, COND_ALWAYS, 1'b0, UPC_IDLE},
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b0, 1'b0, COND_ALWAYS, 1'b0, UPC_IDLE},
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b0, 1'b0, COND_ALWAYS, 1'b0, UPC_IDLE},
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b0, 1'b0, COND_ALWAYS, 1'b0, UPC_IDLE},
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b0, 1'b0, COND_ALWAYS, 1'b0, UPC_IDLE},
      '{NBR_CENTER, CAP_NONE,   3'd0, 1'b0, 1'b0, COND_ALWAYS, 1'b0, UPC_IDLE}
   };

endpackage

/* src/vfc_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_sequencer
// Step counter over the program ROM with conditional jumps or holds on datapath status.
// ----------------------------------------------------------------------------
module vfc_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  vfc_pkg::seq_status_type status,
   output vfc_pkg::ctrl_word_type  cw
);

   logic [vfc_pkg::UPC_BITS-1:0] upc_ff;
   logic [vfc_pkg::UPC_BITS-1:0] upc_in;
   logic                         cond_hit;

   assign cw = vfc_pkg::PROGRAM[upc_ff];

   always_comb begin
      unique case (cw.cond)
         vfc_pkg::COND_NEVER:  cond_hit = 1'b0;
         vfc_pkg::COND_ALWAYS: cond_hit = 1'b1;
         vfc_pkg::COND_GO:     cond_hit = status.go;
         vfc_pkg::COND_AIR:    cond_hit = status.air;
         vfc_pkg::COND_LAST:   cond_hit = status.emit_last;
         default:              cond_hit = 1'b1;
      endcase
      if (cond_hit) begin
         upc_in = cw.target;
      end else if (cw.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= vfc_pkg::UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

`ifndef SYNTHESIS
   a_upc_in_program: assert property (@(posedge clock) disable iff (reset)
      32'(upc_ff) < vfc_pkg::PROG_LEN)
      else $error("step counter left the program");

   a_center_from_idle: assert property (@(posedge clock) disable iff (reset)
      upc_ff == vfc_pkg::UPC_CENTER |-> $past(upc_ff) == vfc_pkg::UPC_IDLE)
      else $error("center read not entered from idle");

   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      upc_ff == vfc_pkg::UPC_EMIT |->
         ($past(upc_ff) == vfc_pkg::UPC_EMIT || $past(upc_ff) == vfc_pkg::UPC_EMIT - 1'b1))
      else $error("emit step entered out of order");
`endif

endmodule

/* src/vfc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfc_datapath
// Voxel store, neighbor addressing, visibility capture and result register.
// ----------------------------------------------------------------------------
module vfc_datapath #(
   parameter int MAX_WIDTH  = vfc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = vfc_pkg::DEF_MAX_HEIGHT,
   parameter int TYPE_BITS  = vfc_pkg::DEF_TYPE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  vfc_pkg::ctrl_word_type  cw,
   output vfc_pkg::seq_status_type status,
   input  logic [4:0]              width_use,
   input  logic [8:0]              height_use,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic [3:0]              req_pos_x,
   input  logic [7:0]              req_pos_y,
   input  logic [3:0]              req_pos_z,
   input  logic [7:0]              req_voxel_type,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3:0]              rsp_face_x,
   output logic [7:0]              rsp_face_y,
   output logic [3:0]              rsp_face_z,
   output logic [7:0]              rsp_face_type,
   output logic [2:0]              rsp_face_dir,
   output logic                    rsp_last_face
);

   localparam int XB    = $clog2(MAX_WIDTH);
   localparam int YB    = $clog2(MAX_HEIGHT);
   localparam int XW    = (XB > 4) ? XB : 4;
   localparam int YW    = (YB > 8) ? YB : 8;
   localparam int AW    = YB + 2 * XB;
   localparam int DEPTH = 2 ** AW;

   logic [TYPE_BITS-1:0] store [DEPTH];

   logic [3:0]                  x_ff;
   logic [7:0]                  y_ff;
   logic [3:0]                  z_ff;
   logic [TYPE_BITS-1:0]        type_ff;
   logic [TYPE_BITS-1:0]        rd_data_ff;
   logic [vfc_pkg::NUM_DIRS-1:0] vis_ff;
   logic                        rsp_valid_ff;
   logic [3:0]                  rsp_face_x_ff;
   logic [7:0]                  rsp_face_y_ff;
   logic [3:0]                  rsp_face_z_ff;
   logic [7:0]                  rsp_face_type_ff;
   logic [2:0]                  rsp_face_dir_ff;
   logic                        rsp_last_face_ff;

   logic                        accept;
   logic                        in_chunk;
   logic                        in_store;
   logic                        mem_we;
   logic [AW-1:0]               wr_addr;
   logic [AW-1:0]               rd_addr;
   logic [XW-1:0]               nx;
   logic [YW-1:0]               ny;
   logic [XW-1:0]               nz;
   logic                        air;
   logic [vfc_pkg::NUM_DIRS-1:0] nbr_ok;
   logic [vfc_pkg::NUM_DIRS-1:0] pick;
   logic [vfc_pkg::NUM_DIRS-1:0] rest;
   logic [2:0]                  pick_dir;
   logic                        found;
   logic                        slot_free;
   logic                        load;

   function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] xa,
                                                input logic [YW-1:0] ya,
                                                input logic [XW-1:0] za);
      return {ya[YB-1:0], xa[XB-1:0], za[XB-1:0]};
   endfunction

   assign req_ready = cw.take && !reset;
   assign accept    = req_valid && req_ready;

   assign in_chunk = ({1'b0, req_pos_x} < width_use) && ({1'b0, req_pos_z} < width_use) &&
                     ({1'b0, req_pos_y} < height_use);
   assign in_store = (32'(req_pos_x) < MAX_WIDTH) && (32'(req_pos_z) < MAX_WIDTH) &&
                     (32'(req_pos_y) < MAX_HEIGHT);
   assign mem_we   = accept && (req_action == vfc_pkg::ACT_WRITE) && in_store;
   assign wr_addr  = cell_addr(XW'(req_pos_x), YW'(req_pos_y), XW'(req_pos_z));

   // neighbor coordinates wrap harmlessly: out-of-chunk sides are masked by nbr_ok
   always_comb begin
      nx = XW'(x_ff);
      ny = YW'(y_ff);
      nz = XW'(z_ff);
      unique case (cw.sel)
         vfc_pkg::NBR_LEFT:   nx = XW'(x_ff) - XW'(1);
         vfc_pkg::NBR_RIGHT:  nx = XW'(x_ff) + XW'(1);
         vfc_pkg::NBR_FRONT:  nz = XW'(z_ff) - XW'(1);
         vfc_pkg::NBR_BACK:   nz = XW'(z_ff) + XW'(1);
         vfc_pkg::NBR_BOTTOM: ny = YW'(y_ff) - YW'(1);
         vfc_pkg::NBR_TOP:    ny = YW'(y_ff) + YW'(1);
         vfc_pkg::NBR_CENTER: ;
         default: ;
      endcase
   end

   assign rd_addr = cell_addr(nx, ny, nz);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wr_addr] <= TYPE_BITS'(req_voxel_type);
      end
      rd_data_ff <= store[rd_addr];
   end

   assign air = (rd_data_ff == '0);

   assign nbr_ok[0] = (x_ff != 4'd0);
   assign nbr_ok[1] = (({1'b0, x_ff} + 5'd1) < width_use);
   assign nbr_ok[2] = (z_ff != 4'd0);
   assign nbr_ok[3] = (({1'b0, z_ff} + 5'd1) < width_use);
   assign nbr_ok[4] = (y_ff != 8'd0);
   assign nbr_ok[5] = (({1'b0, y_ff} + 9'd1) < height_use);

   // lowest pending side goes out first
   always_comb begin
      pick     = '0;
      pick_dir = '0;
      found    = 1'b0;
      for (int d = 0; d < vfc_pkg::NUM_DIRS; d++) begin
         if (vis_ff[d] && !found) begin
            pick[d]  = 1'b1;
            pick_dir = 3'(d);
            found    = 1'b1;
         end
      end
   end

   assign rest      = vis_ff & ~pick;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load      = cw.emit && found && slot_free;

   assign status.go        = accept && (req_action == vfc_pkg::ACT_QUERY) && in_chunk;
   assign status.air       = air;
   assign status.emit_last = cw.emit && (!found || (slot_free && (rest == '0)));

   // query payload and captured values
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_pos_x;
         y_ff <= req_pos_y;
         z_ff <= req_pos_z;
      end
      if (cw.cap == vfc_pkg::CAP_CENTER) begin
         type_ff <= rd_data_ff;
      end
      if (load) begin
         rsp_face_x_ff    <= x_ff;
         rsp_face_y_ff    <= y_ff;
         rsp_face_z_ff    <= z_ff;
         rsp_face_type_ff <= 8'(type_ff);
         rsp_face_dir_ff  <= pick_dir;
         rsp_last_face_ff <= (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cw.cap == vfc_pkg::CAP_CENTER) begin
            vis_ff <= '0;
         end else if (cw.cap == vfc_pkg::CAP_VIS) begin
            vis_ff[cw.vis_idx] <= nbr_ok[cw.vis_idx] && air;
         end else if (load) begin
            vis_ff <= rest;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_face_x    = rsp_face_x_ff;
   assign rsp_face_y    = rsp_face_y_ff;
   assign rsp_face_z    = rsp_face_z_ff;
   assign rsp_face_type = rsp_face_type_ff;
   assign rsp_face_dir  = rsp_face_dir_ff;
   assign rsp_last_face = rsp_last_face_ff;

`ifndef SYNTHESIS
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      load && (rest == '0) |=> vis_ff == '0)
      else $error("sides still pending after last word");

   a_word_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cw.emit))
      else $error("result word loaded outside emit step");

   a_no_write_in_query: assert property (@(posedge clock) disable iff (reset)
      cw.cap != vfc_pkg::CAP_NONE |-> !req_ready)
      else $error("input taken while a query is in flight");
`endif

endmodule

/* src/voxel_face_culler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culler
// Chunk voxel store that lists the visible (air-facing) sides of a voxel.
// ----------------------------------------------------------------------------
// Write word: stored when taken, next word accepted the following cycle.
// Query word: 8 steps (7 reads on the store's one read port plus capture of
// the last), then one emit step per visible side plus output stalls; the
// first face is registered from the emit step. No word is taken until a query
// ends: air at the center capture, out-of-chunk in idle. Reset clears control,
// sizes back to 16 x 256; store not cleared, write before use.
module voxel_face_culler #(
   parameter int MAX_WIDTH  = vfc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = vfc_pkg::DEF_MAX_HEIGHT,
   parameter int TYPE_BITS  = vfc_pkg::DEF_TYPE_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [8:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [3:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic [3:0] req_pos_z,
   input  logic [7:0] req_voxel_type,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_face_x,
   output logic [7:0] rsp_face_y,
   output logic [3:0] rsp_face_z,
   output logic [7:0] rsp_face_type,
   output logic [2:0] rsp_face_dir,
   output logic       rsp_last_face
);

   localparam logic [4:0] WIDTH_RST  = (MAX_WIDTH < 16) ? 5'(MAX_WIDTH) : 5'd16;
   localparam logic [8:0] HEIGHT_RST = (MAX_HEIGHT < 256) ? 9'(MAX_HEIGHT) : 9'd256;

   logic [4:0] width_use_ff;
   logic [4:0] width_use_in;
   logic [8:0] height_use_ff;
   logic [8:0] height_use_in;

   vfc_pkg::ctrl_word_type  cw;
   vfc_pkg::seq_status_type status;

   // sizes saturate to 1..MAX
   always_comb begin
      width_use_in  = csr_wdata[4:0];
      height_use_in = csr_wdata;
      if (csr_wdata[4:0] == 5'd0) begin
         width_use_in = 5'd1;
      end else if (32'(csr_wdata[4:0]) > MAX_WIDTH) begin
         width_use_in = 5'(MAX_WIDTH);
      end
      if (csr_wdata == 9'd0) begin
         height_use_in = 9'd1;
      end else if (32'(csr_wdata) > MAX_HEIGHT) begin
         height_use_in = 9'(MAX_HEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_use_ff  <= WIDTH_RST;
         height_use_ff <= HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            vfc_pkg::CSR_WIDTH:  width_use_ff  <= width_use_in;
            vfc_pkg::CSR_HEIGHT: height_use_ff <= height_use_in;
            default: ;
         endcase
      end
   end

   vfc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   vfc_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .TYPE_BITS  (TYPE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cw             (cw),
      .status         (status),
      .width_use      (width_use_ff),
      .height_use     (height_use_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_voxel_type (req_voxel_type),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_face_x     (rsp_face_x),
      .rsp_face_y     (rsp_face_y),
      .rsp_face_z     (rsp_face_z),
      .rsp_face_type  (rsp_face_type),
      .rsp_face_dir   (rsp_face_dir),
      .rsp_last_face  (rsp_last_face)
   );

endmodule

/* sim/voxel_face_culler_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_face_culler_test
// Self-checking bench for the voxel face culler. A small corner block of the
// store is filled first; the bench tracks which entries are written and never
// sends a query that would read an unwritten one. Directed tests cover size
// saturation, a lone voxel, a hidden voxel, air, out-of-chunk queries and the
// far corner. Random phases follow under several chunk sizes. A local
// predictor queues the expected faces. Sender bursts and receiver stalls are
// random.
// ----------------------------------------------------------------------------
module voxel_face_culler_test;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 6;
   localparam int IDLE_LIMIT    = 2000;  // cycles with no word moved on either side
   localparam int SETTLE_CYCLES = 20;    // covers a query that ends with no face
   localparam int STORE_DEPTH   = vfc_pkg::DEF_MAX_WIDTH * vfc_pkg::DEF_MAX_WIDTH *
                                  vfc_pkg::DEF_MAX_HEIGHT;
   localparam int FILL_SPAN     = 4;     // corner block written up front
   localparam int RAND_SPAN     = 6;     // most random coordinates stay near the corner
   localparam int PHASE_ITEMS   = 28;

   typedef struct packed {
      logic [3:0]           x;
      logic [7:0]           y;
      logic [3:0]           z;
      logic [7:0]           vtype;
      vfc_pkg::nbr_sel_type dir;
      logic                 last;
   } face_word_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_we         = 1'b0;
   logic       csr_index      = vfc_pkg::CSR_WIDTH;
   logic [8:0] csr_wdata      = '0;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic       req_action     = vfc_pkg::ACT_WRITE;
   logic [3:0] req_pos_x      = '0;
   logic [7:0] req_pos_y      = '0;
   logic [3:0] req_pos_z      = '0;
   logic [7:0] req_voxel_type = '0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [3:0] rsp_face_x;
   logic [7:0] rsp_face_y;
   logic [3:0] rsp_face_z;
   logic [7:0] rsp_face_type;
   logic [2:0] rsp_face_dir;
   logic       rsp_last_face;

   // predictor state
   logic [7:0]    voxel_mirror [0:STORE_DEPTH-1];
   bit            voxel_known  [0:STORE_DEPTH-1];
   int            chunk_width  = vfc_pkg::DEF_MAX_WIDTH;
   int            chunk_height = vfc_pkg::DEF_MAX_HEIGHT;
   face_word_type expected_faces [$];

   int   fault_count = 0;
   int   idle_cycles = 0;
   logic pace_on     = 1'b0;
   int   burst_left  = 0;

   // receiver stall pattern
   int stall_period = 1;
   int stall_busy   = 0;
   int stall_phase  = 0;
   int pattern_left = 0;

   voxel_face_culler DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_voxel_type (req_voxel_type),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_face_x     (rsp_face_x),
      .rsp_face_y     (rsp_face_y),
      .rsp_face_z     (rsp_face_z),
      .rsp_face_type  (rsp_face_type),
      .rsp_face_dir   (rsp_face_dir),
      .rsp_last_face  (rsp_last_face)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic logic [7:0] mirror_at(input int x, input int y, input int z);
      return voxel_mirror[(y * vfc_pkg::DEF_MAX_WIDTH + x) * vfc_pkg::DEF_MAX_WIDTH + z];
   endfunction

   // entries outside the chunk never affect a result, so they count as known
   function automatic bit known_at(input int x, input int y, input int z);
      if (x < 0 || y < 0 || z < 0 || x >= chunk_width || z >= chunk_width ||
          y >= chunk_height) return 1'b1;
      return voxel_known[(y * vfc_pkg::DEF_MAX_WIDTH + x) * vfc_pkg::DEF_MAX_WIDTH + z];
   endfunction

   function automatic bit query_defined(input int x, input int y, input int z);
      if (x >= chunk_width || z >= chunk_width || y >= chunk_height) return 1'b1;
      return known_at(x, y, z) && known_at(x - 1, y, z) && known_at(x + 1, y, z) &&
             known_at(x, y, z - 1) && known_at(x, y, z + 1) &&
             known_at(x, y - 1, z) && known_at(x, y + 1, z);
   endfunction

   // queue the faces of one query in side order, last one flagged
   task automatic predict_faces(input int x, input int y, input int z);
      logic [7:0]    vtype;
      logic          vis [vfc_pkg::NUM_DIRS];
      int            last_dir;
      face_word_type f;
      if (x >= chunk_width || z >= chunk_width || y >= chunk_height) return;
      vtype = mirror_at(x, y, z);
      if (vtype == 8'd0) return;
      vis[vfc_pkg::NBR_LEFT]   = x > 0 && mirror_at(x - 1, y, z) == 8'd0;
      vis[vfc_pkg::NBR_RIGHT]  = x + 1 < chunk_width && mirror_at(x + 1, y, z) == 8'd0;
      vis[vfc_pkg::NBR_FRONT]  = z > 0 && mirror_at(x, y, z - 1) == 8'd0;
      vis[vfc_pkg::NBR_BACK]   = z + 1 < chunk_width && mirror_at(x, y, z + 1) == 8'd0;
      vis[vfc_pkg::NBR_BOTTOM] = y > 0 && mirror_at(x, y - 1, z) == 8'd0;
      vis[vfc_pkg::NBR_TOP]    = y + 1 < chunk_height && mirror_at(x, y + 1, z) == 8'd0;
      last_dir = -1;
      for (int d = 0; d < vfc_pkg::NUM_DIRS; d++) if (vis[d]) last_dir = d;
      for (int d = 0; d < vfc_pkg::NUM_DIRS; d++) begin
         if (vis[d]) begin
            f.x     = x[3:0];
            f.y     = y[7:0];
            f.z     = z[3:0];
            f.vtype = vtype;
            f.dir   = vfc_pkg::nbr_sel_type'(d);
            f.last  = (d == last_dir);
            expected_faces = {expected_faces, f};
         end
      end
   endtask

   function int next_gap();
      if (!pace_on) return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(30, 60)) :
                                                 int'($urandom_range(0, 10));
      return int'($urandom_range(0, 8));
   endfunction

   task automatic send_word(input logic act, input logic [3:0] x, input logic [7:0] y,
                            input logic [3:0] z, input logic [7:0] vtype);
      int gap;
      gap = next_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_pos_z      <= z;
      req_voxel_type <= vtype;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act == vfc_pkg::ACT_WRITE) begin
         voxel_mirror[{y, x, z}] = vtype;
         voxel_known[{y, x, z}]  = 1'b1;
      end else begin
         predict_faces(int'(x), int'(y), int'(z));
      end
   endtask

   // drop valid, drain all faces, then let a faceless query finish
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_faces.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_chunk(input logic [8:0] w_raw, input logic [8:0] h_raw);
      int w;
      int h;
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= vfc_pkg::CSR_WIDTH;
      csr_wdata <= w_raw;
      @(negedge clock);
      csr_index <= vfc_pkg::CSR_HEIGHT;
      csr_wdata <= h_raw;
      @(negedge clock);
      csr_we    <= 1'b0;
      w = int'(w_raw[4:0]);
      h = int'(h_raw);
      chunk_width  = (w < 1) ? 1 : (w > vfc_pkg::DEF_MAX_WIDTH) ? vfc_pkg::DEF_MAX_WIDTH : w;
      chunk_height = (h < 1) ? 1 : (h > vfc_pkg::DEF_MAX_HEIGHT) ? vfc_pkg::DEF_MAX_HEIGHT : h;
   endtask

   function automatic logic [7:0] rand_type();
      return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
   endfunction

   function automatic int span_of(input int size);
      return (size < RAND_SPAN) ? size : RAND_SPAN;
   endfunction

   // a query that would read an unwritten entry becomes a write there
   task automatic send_query_checked(input int x, input int y, input int z);
      if (query_defined(x, y, z))
         send_word(vfc_pkg::ACT_QUERY, 4'(x), 8'(y), 4'(z), 8'($urandom_range(0, 255)));
      else
         send_word(vfc_pkg::ACT_WRITE, 4'(x), 8'(y), 4'(z), rand_type());
   endtask

   task automatic test_fill_region();
      pace_on = 1'b0;
      for (int y = 0; y < FILL_SPAN; y++)
         for (int x = 0; x < FILL_SPAN; x++)
            for (int z = 0; z < FILL_SPAN; z++)
               send_word(vfc_pkg::ACT_WRITE, 4'(x), 8'(y), 4'(z), rand_type());
      pace_on = 1'b1;
   endtask

   task automatic test_size_saturation();
      set_chunk(9'h000, 9'h000);                  // clamps to a single cell
      send_word(vfc_pkg::ACT_WRITE, 4'd0, 8'd0, 4'd0, 8'hFF);
      send_word(vfc_pkg::ACT_QUERY, 4'd0, 8'd0, 4'd0, 8'h00); // all sides on the border
      send_word(vfc_pkg::ACT_QUERY, 4'd1, 8'd0, 4'd0, 8'hFF);
      send_word(vfc_pkg::ACT_QUERY, 4'd0, 8'd1, 4'd0, 8'h00);
      set_chunk(9'h1F1, 9'h1FF);                  // both above max
      send_word(vfc_pkg::ACT_QUERY, 4'd0, 8'd0, 4'd0, 8'h00);
   endtask

   task automatic test_lone_voxel();
      set_chunk(9'h1E3, 9'h003);                  // upper width bits are dropped
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd1, 4'd1, 8'hFF);
      send_word(vfc_pkg::ACT_WRITE, 4'd0, 8'd1, 4'd1, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd2, 8'd1, 4'd1, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd1, 4'd0, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd1, 4'd2, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd0, 4'd1, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd2, 4'd1, 8'h00);
      send_word(vfc_pkg::ACT_QUERY, 4'd1, 8'd1, 4'd1, 8'h00); // six faces
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd1, 4'd2, 8'h01);
      send_word(vfc_pkg::ACT_QUERY, 4'd1, 8'd1, 4'd1, 8'hFF);
   endtask

   task automatic test_hidden_voxel();
      send_word(vfc_pkg::ACT_WRITE, 4'd0, 8'd1, 4'd1, 8'h02);
      send_word(vfc_pkg::ACT_WRITE, 4'd2, 8'd1, 4'd1, 8'h7F);
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd1, 4'd0, 8'h80);
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd0, 4'd1, 8'h55);
      send_word(vfc_pkg::ACT_WRITE, 4'd1, 8'd2, 4'd1, 8'hAA);
      send_word(vfc_pkg::ACT_QUERY, 4'd1, 8'd1, 4'd1, 8'h00);
   endtask

   task automatic test_outside_and_air();
      send_word(vfc_pkg::ACT_WRITE, 4'd2, 8'd2, 4'd2, 8'h00);
      send_word(vfc_pkg::ACT_QUERY, 4'd2, 8'd2, 4'd2, 8'hFF); // air
      send_word(vfc_pkg::ACT_QUERY, 4'd3, 8'd0, 4'd0, 8'h00);
      send_word(vfc_pkg::ACT_QUERY, 4'd0, 8'd0, 4'd3, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd15, 8'd200, 4'd15, 8'hA5); // beyond chunk, still stored
   endtask

   task automatic test_far_corner();
      set_chunk(9'h010, 9'h100);
      send_word(vfc_pkg::ACT_WRITE, 4'd14, 8'd200, 4'd15, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd15, 8'd200, 4'd14, 8'h33);
      send_word(vfc_pkg::ACT_WRITE, 4'd15, 8'd199, 4'd15, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd15, 8'd201, 4'd15, 8'h44);
      send_word(vfc_pkg::ACT_QUERY, 4'd15, 8'd200, 4'd15, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd15, 8'd255, 4'd15, 8'h80);
      send_word(vfc_pkg::ACT_WRITE, 4'd15, 8'd254, 4'd15, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd14, 8'd255, 4'd15, 8'h00);
      send_word(vfc_pkg::ACT_WRITE, 4'd15, 8'd255, 4'd14, 8'h12);
      send_word(vfc_pkg::ACT_QUERY, 4'd15, 8'd255, 4'd15, 8'hFF);
   endtask

   task automatic test_random_chunks();
      logic [8:0] w_list [8];
      logic [8:0] h_list [8];
      int         r;
      int         x;
      int         y;
      int         z;
      w_list = '{9'd2, 9'd1, 9'd16, 9'd4, 9'd16, 9'd0, 9'd0, 9'd3};
      h_list = '{9'd2, 9'd256, 9'd1, 9'd5, 9'd256, 9'd0, 9'd0, 9'd300};
      for (int p = 0; p < 8; p++) begin
         if (p == 5 || p == 6) set_chunk(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
         else set_chunk(w_list[p], h_list[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = int'($urandom_range(0, 99));
            x = int'($urandom_range(0, span_of(chunk_width) - 1));
            y = int'($urandom_range(0, span_of(chunk_height) - 1));
            z = int'($urandom_range(0, span_of(chunk_width) - 1));
            if (r < 35)
               send_word(vfc_pkg::ACT_WRITE, 4'(x), 8'(y), 4'(z), rand_type());
            else if (r < 85)
               send_query_checked(x, y, z);
            else if (r < 93)
               send_word(vfc_pkg::ACT_WRITE, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
            else
               send_query_checked(int'($urandom_range(0, 15)), int'($urandom_range(0, 255)),
                                  int'($urandom_range(0, 15)));
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_fill_region();
      test_size_saturation();
      test_lone_voxel();
      test_hidden_voxel();
      test_outside_and_air();
      test_far_corner();
      test_random_chunks();
      wait_idle();
      if (fault_count == 0 && expected_faces.size() == 0) begin
         $display("voxel_face_culler: match");
      end else begin
         $display("voxel_face_culler: mismatch");
      end
      $finish;
   end

   // receiver: periodic stall pattern, re-rolled when pattern_left runs out
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         pattern_left = 64;
         stall_phase  = 0;
         stall_period = int'($urandom_range(1, 9));
         stall_busy   = ($urandom_range(0, 3) == 0) ? 0 :
                        int'($urandom_range(0, stall_period - 1));
      end
      rsp_ready <= (stall_phase % stall_period) >= stall_busy;
      stall_phase++;
      pattern_left--;
   end

   always @(posedge clock) begin
      face_word_type f;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_faces.size() == 0) begin
            $error("unexpected face word: x %0d y %0d z %0d dir %0d",
                   rsp_face_x, rsp_face_y, rsp_face_z, rsp_face_dir);
            fault_count++;
         end else begin
            f = expected_faces.pop_front();
            if (rsp_face_x !== f.x) begin
               $error("face_x: expected %0d, actual %0d", f.x, rsp_face_x);
               fault_count++;
            end
            if (rsp_face_y !== f.y) begin
               $error("face_y: expected %0d, actual %0d", f.y, rsp_face_y);
               fault_count++;
            end
            if (rsp_face_z !== f.z) begin
               $error("face_z: expected %0d, actual %0d", f.z, rsp_face_z);
               fault_count++;
            end
            if (rsp_face_type !== f.vtype) begin
               $error("face_type: expected %0d, actual %0d", f.vtype, rsp_face_type);
               fault_count++;
            end
            if (rsp_face_dir !== f.dir) begin
               $error("face_dir: expected %0d, actual %0d", f.dir, rsp_face_dir);
               fault_count++;
            end
            if (rsp_last_face !== f.last) begin
               $error("last_face: expected %0d, actual %0d", f.last, rsp_last_face);
               fault_count++;
            end
         end
      end
   end

   // watchdog: nothing moved on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("voxel_face_culler: mismatch");
            $finish;
         end
      end
   end

endmodule
